// ----- rtl/cfgd_pkg.sv -----
// shared types, constants and saturating arithmetic for the cubic fit block
package cfgd_pkg;

  // default sample store depth
  localparam int unsigned DEF_MAX_SAMPLES = 1024;

  // field widths
  localparam int unsigned COEF_W    = 64;
  localparam int unsigned X_W       = 8;
  localparam int unsigned Y_W       = 16;
  localparam int unsigned ITER_W    = 24;
  localparam int unsigned LR_W      = 32;
  localparam int unsigned THR_W     = 32;
  localparam int unsigned SQ_W      = 16;
  localparam int unsigned PW_W      = 22;
  localparam int unsigned PROD_W    = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned DIV_CNT_W = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONV_THRESH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_CUBIC    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_SQUARE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_LINEAR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_OFFSET   = 3'd6;

  // register reset values
  localparam logic [LR_W-1:0]          RST_LEARNING_RATE = 32'd429497;
  localparam logic [THR_W-1:0]         RST_CONV_THRESH   = 32'd43;
  localparam logic [ITER_W-1:0]        RST_MAX_ITER      = 24'd1000000;
  localparam logic signed [COEF_W-1:0] RST_INIT_CUBIC    = 64'sd429496729600;
  localparam logic signed [COEF_W-1:0] RST_INIT_SQUARE   = -64'sd429496729600;
  localparam logic signed [COEF_W-1:0] RST_INIT_LINEAR   = 64'sd343597383680;
  localparam logic signed [COEF_W-1:0] RST_INIT_OFFSET   = 64'sd0;

  localparam logic signed [COEF_W-1:0] S64_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] S64_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_STORE,
    OP_LOAD_INIT,
    OP_ITER_BEGIN,
    OP_READ,
    OP_SQUARE,
    OP_CUBE,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_MUL_FIN,
    OP_ACC_PRED,
    OP_ADD_OFS,
    OP_SUB_Y,
    OP_ACC_GRAD,
    OP_ACC_RESID,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_RATE_LO,
    OP_RATE_HI,
    OP_STEP,
    OP_APPLY,
    OP_CHECK,
    OP_FINISH
  } op_t;

  // controller states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INIT,
    ST_ITER,
    ST_RD,
    ST_SQ,
    ST_CU,
    ST_P_LO,
    ST_P_HI,
    ST_P_FIN,
    ST_P_ACC,
    ST_OFS,
    ST_SUBY,
    ST_G_LO,
    ST_G_HI,
    ST_G_FIN,
    ST_G_ACC,
    ST_SUM3,
    ST_DIVS,
    ST_DIVW,
    ST_R_LO,
    ST_R_HI,
    ST_STEP,
    ST_APPLY,
    ST_CHECK,
    ST_DECIDE,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    op_t  op;
    logic resid;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic sample_last;
    logic term_last;
    logic coef_last;
    logic div_last;
    logic iter_cap;
    logic all_conv;
  } status_t;

  // magnitude of a signed 64 bit value
  function automatic logic [COEF_W-1:0] mag64(input logic signed [COEF_W-1:0] a);
    mag64 = a[COEF_W-1] ? COEF_W'(-a) : COEF_W'(a);
  endfunction

  // signed value from magnitude and sign, saturated
  function automatic logic signed [COEF_W-1:0] from_mag64(input logic [COEF_W-1:0] m,
                                                          input logic neg);
    if (neg) begin
      from_mag64 = m[COEF_W-1] ? S64_MIN : -$signed(m);
    end else begin
      from_mag64 = m[COEF_W-1] ? S64_MAX : $signed(m);
    end
  endfunction

  // saturating add
  function automatic logic signed [COEF_W-1:0] sat_add64(input logic signed [COEF_W-1:0] a,
                                                         input logic signed [COEF_W-1:0] b);
    logic signed [COEF_W:0] s;
    s = {a[COEF_W-1], a} + {b[COEF_W-1], b};
    if (s[COEF_W] != s[COEF_W-1]) begin
      sat_add64 = s[COEF_W] ? S64_MIN : S64_MAX;
    end else begin
      sat_add64 = s[COEF_W-1:0];
    end
  endfunction

  // saturating subtract
  function automatic logic signed [COEF_W-1:0] sat_sub64(input logic signed [COEF_W-1:0] a,
                                                         input logic signed [COEF_W-1:0] b);
    logic signed [COEF_W:0] s;
    s = {a[COEF_W-1], a} - {b[COEF_W-1], b};
    if (s[COEF_W] != s[COEF_W-1]) begin
      sat_sub64 = s[COEF_W] ? S64_MIN : S64_MAX;
    end else begin
      sat_sub64 = s[COEF_W-1:0];
    end
  endfunction

  // unsigned distance between two signed values
  function automatic logic [COEF_W-1:0] dist64(input logic signed [COEF_W-1:0] a,
                                               input logic signed [COEF_W-1:0] b);
    logic signed [COEF_W:0] d;
    d = {a[COEF_W-1], a} - {b[COEF_W-1], b};
    dist64 = d[COEF_W] ? COEF_W'(-d) : d[COEF_W-1:0];
  endfunction

endpackage

// ----- rtl/cfgd_ctrl.sv -----
// sequencer for sample loading and the gradient descent iterations
module cfgd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              last_sample,
  output logic              out_valid,
  input  logic              out_ready,
  input  cfgd_pkg::status_t sts,
  output cfgd_pkg::cmd_t    cmd
);

  cfgd_pkg::state_t state, state_next;
  logic             out_valid_next;
  logic             slot_free;

  assign slot_free = !out_valid || out_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cfgd_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cfgd_pkg::ST_IDLE: begin
        if (in_valid && last_sample) state_next = cfgd_pkg::ST_INIT;
      end
      cfgd_pkg::ST_INIT:  state_next = cfgd_pkg::ST_ITER;
      cfgd_pkg::ST_ITER: begin
        if (sts.iter_cap) state_next = cfgd_pkg::ST_FINISH;
        else if (sts.empty) state_next = cfgd_pkg::ST_DIVS;
        else state_next = cfgd_pkg::ST_RD;
      end
      cfgd_pkg::ST_RD:    state_next = cfgd_pkg::ST_SQ;
      cfgd_pkg::ST_SQ:    state_next = cfgd_pkg::ST_CU;
      cfgd_pkg::ST_CU:    state_next = cfgd_pkg::ST_P_LO;
      cfgd_pkg::ST_P_LO:  state_next = cfgd_pkg::ST_P_HI;
      cfgd_pkg::ST_P_HI:  state_next = cfgd_pkg::ST_P_FIN;
      cfgd_pkg::ST_P_FIN: state_next = cfgd_pkg::ST_P_ACC;
      cfgd_pkg::ST_P_ACC: begin
        state_next = sts.term_last ? cfgd_pkg::ST_OFS : cfgd_pkg::ST_P_LO;
      end
      cfgd_pkg::ST_OFS:   state_next = cfgd_pkg::ST_SUBY;
      cfgd_pkg::ST_SUBY:  state_next = cfgd_pkg::ST_G_LO;
      cfgd_pkg::ST_G_LO:  state_next = cfgd_pkg::ST_G_HI;
      cfgd_pkg::ST_G_HI:  state_next = cfgd_pkg::ST_G_FIN;
      cfgd_pkg::ST_G_FIN: state_next = cfgd_pkg::ST_G_ACC;
      cfgd_pkg::ST_G_ACC: begin
        state_next = sts.term_last ? cfgd_pkg::ST_SUM3 : cfgd_pkg::ST_G_LO;
      end
      cfgd_pkg::ST_SUM3: begin
        state_next = sts.sample_last ? cfgd_pkg::ST_DIVS : cfgd_pkg::ST_RD;
      end
      cfgd_pkg::ST_DIVS:  state_next = cfgd_pkg::ST_DIVW;
      cfgd_pkg::ST_DIVW: begin
        if (sts.div_last) state_next = cfgd_pkg::ST_R_LO;
      end
      cfgd_pkg::ST_R_LO:  state_next = cfgd_pkg::ST_R_HI;
      cfgd_pkg::ST_R_HI:  state_next = cfgd_pkg::ST_STEP;
      cfgd_pkg::ST_STEP:  state_next = cfgd_pkg::ST_APPLY;
      cfgd_pkg::ST_APPLY: state_next = cfgd_pkg::ST_CHECK;
      cfgd_pkg::ST_CHECK: begin
        state_next = sts.coef_last ? cfgd_pkg::ST_DECIDE : cfgd_pkg::ST_DIVS;
      end
      cfgd_pkg::ST_DECIDE: begin
        state_next = sts.all_conv ? cfgd_pkg::ST_FINISH : cfgd_pkg::ST_ITER;
      end
      cfgd_pkg::ST_FINISH: begin
        if (slot_free) state_next = cfgd_pkg::ST_IDLE;
      end
      default: state_next = cfgd_pkg::ST_IDLE;
    endcase
  end

  // outputs and commands
  always_comb begin
    cmd.op         = cfgd_pkg::OP_NONE;
    cmd.resid      = 1'b0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      cfgd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = cfgd_pkg::OP_STORE;
      end
      cfgd_pkg::ST_INIT:  cmd.op = cfgd_pkg::OP_LOAD_INIT;
      cfgd_pkg::ST_ITER: begin
        if (!sts.iter_cap) cmd.op = cfgd_pkg::OP_ITER_BEGIN;
      end
      cfgd_pkg::ST_RD:    cmd.op = cfgd_pkg::OP_READ;
      cfgd_pkg::ST_SQ:    cmd.op = cfgd_pkg::OP_SQUARE;
      cfgd_pkg::ST_CU:    cmd.op = cfgd_pkg::OP_CUBE;
      cfgd_pkg::ST_P_LO:  cmd.op = cfgd_pkg::OP_MUL_LO;
      cfgd_pkg::ST_P_HI:  cmd.op = cfgd_pkg::OP_MUL_HI;
      cfgd_pkg::ST_P_FIN: cmd.op = cfgd_pkg::OP_MUL_FIN;
      cfgd_pkg::ST_P_ACC: cmd.op = cfgd_pkg::OP_ACC_PRED;
      cfgd_pkg::ST_OFS:   cmd.op = cfgd_pkg::OP_ADD_OFS;
      cfgd_pkg::ST_SUBY:  cmd.op = cfgd_pkg::OP_SUB_Y;
      cfgd_pkg::ST_G_LO: begin
        cmd.op    = cfgd_pkg::OP_MUL_LO;
        cmd.resid = 1'b1;
      end
      cfgd_pkg::ST_G_HI: begin
        cmd.op    = cfgd_pkg::OP_MUL_HI;
        cmd.resid = 1'b1;
      end
      cfgd_pkg::ST_G_FIN: cmd.op = cfgd_pkg::OP_MUL_FIN;
      cfgd_pkg::ST_G_ACC: cmd.op = cfgd_pkg::OP_ACC_GRAD;
      cfgd_pkg::ST_SUM3:  cmd.op = cfgd_pkg::OP_ACC_RESID;
      cfgd_pkg::ST_DIVS:  cmd.op = cfgd_pkg::OP_DIV_START;
      cfgd_pkg::ST_DIVW:  cmd.op = cfgd_pkg::OP_DIV_STEP;
      cfgd_pkg::ST_R_LO:  cmd.op = cfgd_pkg::OP_RATE_LO;
      cfgd_pkg::ST_R_HI:  cmd.op = cfgd_pkg::OP_RATE_HI;
      cfgd_pkg::ST_STEP:  cmd.op = cfgd_pkg::OP_STEP;
      cfgd_pkg::ST_APPLY: cmd.op = cfgd_pkg::OP_APPLY;
      cfgd_pkg::ST_CHECK: cmd.op = cfgd_pkg::OP_CHECK;
      cfgd_pkg::ST_DECIDE: cmd.op = cfgd_pkg::OP_NONE;
      cfgd_pkg::ST_FINISH: begin
        if (slot_free) begin
          cmd.op         = cfgd_pkg::OP_FINISH;
          out_valid_next = 1'b1;
        end
      end
      default: cmd.op = cfgd_pkg::OP_NONE;
    endcase
  end

`ifndef SYNTHESIS
  // a finished fit always presents a result next cycle
  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.op == cfgd_pkg::OP_FINISH |=> out_valid)
    else $error("result not presented after finish");

  // a fit never finishes over an untaken result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == cfgd_pkg::OP_FINISH) |-> (!out_valid || out_ready))
    else $error("result overwritten");

  // the division wait is only entered straight after a division start
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    $rose(state == cfgd_pkg::ST_DIVW) |-> $past(cmd.op) == cfgd_pkg::OP_DIV_START)
    else $error("division entered without start");
`endif

endmodule

// ----- rtl/cfgd_dp.sv -----
// sample store, shared multiplier, divider and coefficient registers
module cfgd_dp #(
  parameter int unsigned MAX_SAMPLES = cfgd_pkg::DEF_MAX_SAMPLES
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  cfgd_pkg::cmd_t                           cmd,
  output cfgd_pkg::status_t                        sts,
  input  logic signed [cfgd_pkg::X_W-1:0]          sample_x,
  input  logic signed [cfgd_pkg::Y_W-1:0]          sample_y,
  input  logic                                     cfg_valid,
  input  logic [cfgd_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [cfgd_pkg::COEF_W-1:0]              cfg_data,
  output logic signed [cfgd_pkg::COEF_W-1:0]       coef_cubic,
  output logic signed [cfgd_pkg::COEF_W-1:0]       coef_square,
  output logic signed [cfgd_pkg::COEF_W-1:0]       coef_linear,
  output logic signed [cfgd_pkg::COEF_W-1:0]       coef_offset,
  output logic [cfgd_pkg::ITER_W-1:0]              iterations_used,
  output logic                                     converged
);

  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CO = cfgd_pkg::COEF_W;
  localparam int unsigned HW = CO / 2;
  localparam int unsigned YX = CO - cfgd_pkg::Y_W - HW;

  // configuration registers
  logic [cfgd_pkg::LR_W-1:0]     learning_rate;
  logic [cfgd_pkg::THR_W-1:0]    converge_threshold;
  logic [cfgd_pkg::ITER_W-1:0]   max_iterations;
  logic signed [CO-1:0]          init_coef [4];

  // sample store
  logic signed [cfgd_pkg::X_W-1:0] x_mem [MAX_SAMPLES];
  logic signed [cfgd_pkg::Y_W-1:0] y_mem [MAX_SAMPLES];
  logic [CW-1:0]                   count;
  logic [CW-1:0]                   idx;
  logic signed [cfgd_pkg::X_W-1:0] x_rd;
  logic signed [cfgd_pkg::Y_W-1:0] y_rd;

  // powers of x
  logic signed [cfgd_pkg::SQ_W-1:0]             xsq;
  logic signed [cfgd_pkg::PW_W-1:0]             xcu;
  logic signed [cfgd_pkg::SQ_W+cfgd_pkg::X_W-1:0] cu_full;

  // fit state
  logic signed [CO-1:0]          coef [4];
  logic signed [CO-1:0]          sum [4];
  logic signed [CO-1:0]          p;
  logic [1:0]                    j;
  logic [cfgd_pkg::ITER_W-1:0]   iter;
  logic                          done_flag;

  // shared multiplier
  logic signed [CO-1:0]          mul_a;
  logic signed [cfgd_pkg::PW_W-1:0] pw_sel;
  logic [CO-1:0]                 ma;
  logic [cfgd_pkg::PW_W-1:0]     mk;
  logic [HW-1:0]                 mop_a;
  logic [HW-1:0]                 mop_b;
  logic [cfgd_pkg::PROD_W-1:0]   mop_p;
  logic [cfgd_pkg::PROD_W-1:0]   prod_lo;
  logic [cfgd_pkg::PROD_W-1:0]   prod_hi;
  logic                          mneg;
  logic [CO+HW-1:0]              full;
  logic signed [CO-1:0]          mul_res;

  // divider and update
  logic [CO-1:0]                 dq;
  logic [CW-1:0]                 rem;
  logic [CW:0]                   trial;
  logic                          ge;
  logic [cfgd_pkg::DIV_CNT_W-1:0] div_cnt;
  logic                          gneg;
  logic [CO-1:0]                 gq;
  logic [CO-1:0]                 prate;
  logic signed [CO-1:0]          step_r;
  logic signed [CO-1:0]          old_c;
  logic signed [CO-1:0]          y_fix;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate      <= cfgd_pkg::RST_LEARNING_RATE;
      converge_threshold <= cfgd_pkg::RST_CONV_THRESH;
      max_iterations     <= cfgd_pkg::RST_MAX_ITER;
      init_coef[0]       <= cfgd_pkg::RST_INIT_CUBIC;
      init_coef[1]       <= cfgd_pkg::RST_INIT_SQUARE;
      init_coef[2]       <= cfgd_pkg::RST_INIT_LINEAR;
      init_coef[3]       <= cfgd_pkg::RST_INIT_OFFSET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cfgd_pkg::REG_LEARNING_RATE: learning_rate <= cfg_data[cfgd_pkg::LR_W-1:0];
        cfgd_pkg::REG_CONV_THRESH:   converge_threshold <= cfg_data[cfgd_pkg::THR_W-1:0];
        cfgd_pkg::REG_MAX_ITER:      max_iterations <= cfg_data[cfgd_pkg::ITER_W-1:0];
        cfgd_pkg::REG_INIT_CUBIC:    init_coef[0] <= $signed(cfg_data);
        cfgd_pkg::REG_INIT_SQUARE:   init_coef[1] <= $signed(cfg_data);
        cfgd_pkg::REG_INIT_LINEAR:   init_coef[2] <= $signed(cfg_data);
        cfgd_pkg::REG_INIT_OFFSET:   init_coef[3] <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // sample memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.op == cfgd_pkg::OP_STORE && count < CW'(MAX_SAMPLES)) begin
      x_mem[count[AW-1:0]] <= sample_x;
      y_mem[count[AW-1:0]] <= sample_y;
    end
    if (cmd.op == cfgd_pkg::OP_READ) begin
      x_rd <= x_mem[idx[AW-1:0]];
      y_rd <= y_mem[idx[AW-1:0]];
    end
  end

  // operand selection for the shared multiplier
  assign cu_full = xsq * x_rd;
  always_comb begin
    unique case (j)
      2'd0:    pw_sel = xcu;
      2'd1:    pw_sel = cfgd_pkg::PW_W'(xsq);
      2'd2:    pw_sel = cfgd_pkg::PW_W'(x_rd);
      default: pw_sel = '0;
    endcase
  end
  assign mul_a = cmd.resid ? p : coef[j];
  assign ma    = cfgd_pkg::mag64(mul_a);
  assign mk    = pw_sel[cfgd_pkg::PW_W-1] ? cfgd_pkg::PW_W'(-pw_sel) : pw_sel;
  assign gq    = (count == '0) ? '0 : dq;

  // sample target as a sign-extended fixed point value
  assign y_fix = {{YX{y_rd[cfgd_pkg::Y_W-1]}}, y_rd, {HW{1'b0}}};

  always_comb begin
    unique case (cmd.op)
      cfgd_pkg::OP_MUL_LO: begin
        mop_a = ma[HW-1:0];
        mop_b = HW'(mk);
      end
      cfgd_pkg::OP_MUL_HI: begin
        mop_a = ma[CO-1:HW];
        mop_b = HW'(mk);
      end
      cfgd_pkg::OP_RATE_LO: begin
        mop_a = learning_rate;
        mop_b = gq[HW-1:0];
      end
      cfgd_pkg::OP_RATE_HI: begin
        mop_a = learning_rate;
        mop_b = gq[CO-1:HW];
      end
      default: begin
        mop_a = '0;
        mop_b = '0;
      end
    endcase
  end
  assign mop_p = mop_a * mop_b;

  // recombine partial products with saturation
  assign full    = {prod_hi[CO-1:0], {HW{1'b0}}} + (CO+HW)'(prod_lo);
  assign mul_res = (full[CO+HW-1:CO] != '0) ?
                   (mneg ? cfgd_pkg::S64_MIN : cfgd_pkg::S64_MAX) :
                   cfgd_pkg::from_mag64(full[CO-1:0], mneg);

  // rate scaled gradient magnitude
  assign prate = prod_hi + (prod_lo >> HW);

  // one restoring division step
  assign trial = {rem, dq[CO-1]};
  assign ge    = trial >= {1'b0, count};

  // sample counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.op == cfgd_pkg::OP_STORE && count < CW'(MAX_SAMPLES)) begin
      count <= count + 1'b1;
    end else if (cmd.op == cfgd_pkg::OP_FINISH) begin
      count <= '0;
    end
  end

  // iteration counter and convergence flag
  always_ff @(posedge clk) begin
    if (rst) begin
      iter      <= '0;
      done_flag <= 1'b0;
    end else begin
      unique case (cmd.op)
        cfgd_pkg::OP_LOAD_INIT: begin
          iter      <= '0;
          done_flag <= 1'b0;
        end
        cfgd_pkg::OP_ITER_BEGIN: begin
          iter      <= iter + 1'b1;
          done_flag <= 1'b1;
        end
        cfgd_pkg::OP_CHECK: begin
          if (cfgd_pkg::dist64(coef[j], old_c) >= CO'(converge_threshold)) begin
            done_flag <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // arithmetic datapath
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      cfgd_pkg::OP_LOAD_INIT: begin
        for (int k = 0; k < 4; k++) coef[k] <= init_coef[k];
      end
      cfgd_pkg::OP_ITER_BEGIN: begin
        for (int k = 0; k < 4; k++) sum[k] <= '0;
        idx <= '0;
        j   <= '0;
        p   <= '0;
      end
      cfgd_pkg::OP_SQUARE: xsq <= x_rd * x_rd;
      cfgd_pkg::OP_CUBE:   xcu <= cu_full[cfgd_pkg::PW_W-1:0];
      cfgd_pkg::OP_MUL_LO: begin
        prod_lo <= mop_p;
        mneg    <= mul_a[CO-1] ^ pw_sel[cfgd_pkg::PW_W-1];
      end
      cfgd_pkg::OP_MUL_HI: prod_hi <= mop_p;
      cfgd_pkg::OP_MUL_FIN: step_r <= mul_res;
      cfgd_pkg::OP_ACC_PRED: begin
        p <= cfgd_pkg::sat_add64(p, step_r);
        j <= j + 1'b1;
      end
      cfgd_pkg::OP_ADD_OFS: p <= cfgd_pkg::sat_add64(p, coef[3]);
      cfgd_pkg::OP_SUB_Y: begin
        p <= cfgd_pkg::sat_sub64(p, y_fix);
        j <= '0;
      end
      cfgd_pkg::OP_ACC_GRAD: begin
        sum[j] <= cfgd_pkg::sat_add64(sum[j], step_r);
        j      <= j + 1'b1;
      end
      cfgd_pkg::OP_ACC_RESID: begin
        sum[3] <= cfgd_pkg::sat_add64(sum[3], p);
        idx    <= idx + 1'b1;
        j      <= '0;
        p      <= '0;
      end
      cfgd_pkg::OP_DIV_START: begin
        dq      <= cfgd_pkg::mag64(sum[j]);
        gneg    <= sum[j][CO-1];
        rem     <= '0;
        div_cnt <= '1;
      end
      cfgd_pkg::OP_DIV_STEP: begin
        rem     <= ge ? CW'(trial - {1'b0, count}) : trial[CW-1:0];
        dq      <= {dq[CO-2:0], ge};
        div_cnt <= div_cnt - 1'b1;
      end
      cfgd_pkg::OP_RATE_LO: prod_lo <= mop_p;
      cfgd_pkg::OP_RATE_HI: prod_hi <= mop_p;
      cfgd_pkg::OP_STEP:    step_r  <= cfgd_pkg::from_mag64(prate, gneg);
      cfgd_pkg::OP_APPLY: begin
        old_c   <= coef[j];
        coef[j] <= cfgd_pkg::sat_sub64(coef[j], step_r);
      end
      cfgd_pkg::OP_CHECK: j <= j + 1'b1;
      cfgd_pkg::OP_FINISH: begin
        coef_cubic      <= coef[0];
        coef_square     <= coef[1];
        coef_linear     <= coef[2];
        coef_offset     <= coef[3];
        iterations_used <= iter;
        converged       <= done_flag;
      end
      default: ;
    endcase
  end

  // status to the controller
  assign sts.empty       = (count == '0);
  assign sts.sample_last = ((CW+1)'(idx) + 1'b1) == (CW+1)'(count);
  assign sts.term_last   = (j == 2'd2);
  assign sts.coef_last   = (j == 2'd3);
  assign sts.div_last    = (div_cnt == '0);
  assign sts.iter_cap    = (iter >= max_iterations);
  assign sts.all_conv    = done_flag;

`ifndef SYNTHESIS
  // the sample count never passes the store depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SAMPLES))
    else $error("sample count beyond store depth");

  // a delivered fit leaves an empty batch
  a_batch_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.op == cfgd_pkg::OP_FINISH |=> count == '0)
    else $error("batch not cleared after fit");

  // the power select never runs past the linear term
  a_term_range: assert property (@(posedge clk) disable iff (rst)
    cmd.op == cfgd_pkg::OP_MUL_LO |-> j != 2'd3)
    else $error("power select out of range");
`endif

endmodule

// ----- rtl/cubic_fit_gradient_descent.sv -----
// top level of the cubic least-squares fit by batch gradient descent
//
// Samples (sample_x, sample_y) arrive on the in channel, one transaction per
// cycle, and go into the sample store; past the store depth they are dropped.
// The transaction with last_sample set closes the batch and starts the fit:
// the in channel then stalls until the result has been handed to the output
// register. Each iteration walks the stored samples through one shared
// 32x32 multiplier and then divides the four sums by the sample count in
// a bit-serial divider, one coefficient at a time. The fit ends on
// convergence or at max_iterations and places one result transaction on the
// out channel. The output register holds it while the receiver stalls; new
// samples are still taken meanwhile, and the next fit waits for the slot.
// Configuration writes are taken at any cycle (cfg_ready is always high) and
// must only be issued while the block is idle.
// Reset empties the batch, drops any pending result and restores the
// register defaults.
module cubic_fit_gradient_descent #(
  parameter int unsigned MAX_SAMPLES = cfgd_pkg::DEF_MAX_SAMPLES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [cfgd_pkg::X_W-1:0]     sample_x,
  input  logic signed [cfgd_pkg::Y_W-1:0]     sample_y,
  input  logic                                last_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [cfgd_pkg::COEF_W-1:0]  coef_cubic,
  output logic signed [cfgd_pkg::COEF_W-1:0]  coef_square,
  output logic signed [cfgd_pkg::COEF_W-1:0]  coef_linear,
  output logic signed [cfgd_pkg::COEF_W-1:0]  coef_offset,
  output logic [cfgd_pkg::ITER_W-1:0]         iterations_used,
  output logic                                converged,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cfgd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cfgd_pkg::COEF_W-1:0]         cfg_data
);

  cfgd_pkg::cmd_t    cmd;
  cfgd_pkg::status_t sts;

  // configuration always accepted
  assign cfg_ready = 1'b1;

  // controller
  cfgd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .last_sample (last_sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  // datapath
  cfgd_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .sample_x        (sample_x),
    .sample_y        (sample_y),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .coef_cubic      (coef_cubic),
    .coef_square     (coef_square),
    .coef_linear     (coef_linear),
    .coef_offset     (coef_offset),
    .iterations_used (iterations_used),
    .converged       (converged)
  );

endmodule

// ----- tb/cubic_fit_checker.sv -----
// checker for the cubic fit block: watches the channels, predicts each fit and compares
module cubic_fit_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [cfgd_pkg::X_W-1:0]     sample_x,
  input  logic signed [cfgd_pkg::Y_W-1:0]     sample_y,
  input  logic                                last_sample,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [cfgd_pkg::COEF_W-1:0]  coef_cubic,
  input  logic signed [cfgd_pkg::COEF_W-1:0]  coef_square,
  input  logic signed [cfgd_pkg::COEF_W-1:0]  coef_linear,
  input  logic signed [cfgd_pkg::COEF_W-1:0]  coef_offset,
  input  logic [cfgd_pkg::ITER_W-1:0]         iterations_used,
  input  logic                                converged,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [cfgd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cfgd_pkg::COEF_W-1:0]         cfg_data,
  output int                                  fails,
  output int                                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = cfgd_pkg::DEF_MAX_SAMPLES;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic signed [127:0] LIM_HI = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [127:0] LIM_LO = -LIM_HI - 1;

  typedef struct {
    longint                       coef[4];
    logic [cfgd_pkg::ITER_W-1:0]  iters;
    logic                         conv;
  } fit_t;

  // register copy
  logic [cfgd_pkg::LR_W-1:0]   rate;
  logic [cfgd_pkg::THR_W-1:0]  thresh;
  logic [cfgd_pkg::ITER_W-1:0] iter_cap;
  longint                      start_coef[4];

  // sample store copy
  logic signed [cfgd_pkg::X_W-1:0] xs[DEPTH];
  logic signed [cfgd_pkg::Y_W-1:0] ys[DEPTH];
  int                              count;

  int errors = 0;

  fit_t expected_fits[$];

  assign pending = expected_fits.size();
  assign fails = errors;

  function automatic longint clamp(logic signed [127:0] v);
    if (v > LIM_HI) return longint'(LIM_HI);
    if (v < LIM_LO) return longint'(LIM_LO);
    return longint'(v);
  endfunction

  function automatic longint smul(longint a, longint b);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    wa = 128'(a);
    wb = 128'(b);
    return clamp(wa * wb);
  endfunction

  function automatic longint sadd(longint a, longint b);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    wa = 128'(a);
    wb = 128'(b);
    return clamp(wa + wb);
  endfunction

  function automatic longint ssub(longint a, longint b);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    wa = 128'(a);
    wb = 128'(b);
    return clamp(wa - wb);
  endfunction

  // full gradient descent run over the stored batch
  function automatic fit_t predict_fit();
    fit_t r;
    longint c[4], nxt[4], sum[4], pw[4];
    longint x, p, g;
    logic signed [127:0] w;
    logic signed [127:0] lr128;
    logic signed [127:0] thr128;
    int it;
    bit done;
    lr128 = $signed({96'd0, rate});
    thr128 = $signed({96'd0, thresh});
    for (int k = 0; k < 4; k++) c[k] = start_coef[k];
    it = 0;
    done = 0;
    while (it < iter_cap && !done) begin
      it++;
      for (int k = 0; k < 4; k++) sum[k] = 0;
      for (int i = 0; i < count; i++) begin
        x = longint'(xs[i]);
        pw[3] = 1;
        pw[2] = x;
        pw[1] = x * x;
        pw[0] = x * x * x;
        p = smul(c[0], pw[0]);
        p = sadd(p, smul(c[1], pw[1]));
        p = sadd(p, smul(c[2], pw[2]));
        p = sadd(p, c[3]);
        p = ssub(p, longint'(ys[i]) <<< 32);
        for (int k = 0; k < 4; k++) sum[k] = sadd(sum[k], smul(p, pw[k]));
      end
      done = 1;
      for (int k = 0; k < 4; k++) begin
        g = (count != 0) ? sum[k] / longint'(count) : 64'sd0;
        w = 128'(g);
        if (w < 0) w = -w;
        w = (w * lr128) >>> 32;
        if (g < 0) w = -w;
        nxt[k] = ssub(c[k], clamp(w));
        w = 128'(nxt[k]);
        w = w - 128'(c[k]);
        if (w < 0) w = -w;
        if (w >= thr128) done = 0;
      end
      for (int k = 0; k < 4; k++) c[k] = nxt[k];
    end
    for (int k = 0; k < 4; k++) r.coef[k] = c[k];
    r.iters = it[cfgd_pkg::ITER_W-1:0];
    r.conv = done;
    return r;
  endfunction

  task automatic check_field(string name, logic [cfgd_pkg::COEF_W-1:0] want,
                             logic [cfgd_pkg::COEF_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    fit_t want;
    if (rst) begin
      rate <= cfgd_pkg::RST_LEARNING_RATE;
      thresh <= cfgd_pkg::RST_CONV_THRESH;
      iter_cap <= cfgd_pkg::RST_MAX_ITER;
      start_coef[0] <= cfgd_pkg::RST_INIT_CUBIC;
      start_coef[1] <= cfgd_pkg::RST_INIT_SQUARE;
      start_coef[2] <= cfgd_pkg::RST_INIT_LINEAR;
      start_coef[3] <= cfgd_pkg::RST_INIT_OFFSET;
      count = 0;
      expected_fits.delete();
    end else begin
      // register write transaction
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cfgd_pkg::REG_LEARNING_RATE: rate <= cfg_data[cfgd_pkg::LR_W-1:0];
          cfgd_pkg::REG_CONV_THRESH:   thresh <= cfg_data[cfgd_pkg::THR_W-1:0];
          cfgd_pkg::REG_MAX_ITER:      iter_cap <= cfg_data[cfgd_pkg::ITER_W-1:0];
          cfgd_pkg::REG_INIT_CUBIC:    start_coef[0] <= cfg_data;
          cfgd_pkg::REG_INIT_SQUARE:   start_coef[1] <= cfg_data;
          cfgd_pkg::REG_INIT_LINEAR:   start_coef[2] <= cfg_data;
          cfgd_pkg::REG_INIT_OFFSET:   start_coef[3] <= cfg_data;
          default: ;
        endcase
      end
      // sample transaction; a full store drops it
      if (in_valid && in_ready) begin
        if (count < DEPTH) begin
          xs[count[AW-1:0]] = sample_x;
          ys[count[AW-1:0]] = sample_y;
          count++;
        end
        if (last_sample) begin
          expected_fits.push_back(predict_fit());
          count = 0;
        end
      end
      // result transaction
      if (out_valid && out_ready) begin
        if (expected_fits.size() == 0) begin
          $error("result transaction with no fit outstanding");
          errors++;
        end else begin
          want = expected_fits.pop_front();
          check_field("coef_cubic", want.coef[0], coef_cubic);
          check_field("coef_square", want.coef[1], coef_square);
          check_field("coef_linear", want.coef[2], coef_linear);
          check_field("coef_offset", want.coef[3], coef_offset);
          check_field("iterations_used", 64'(want.iters), 64'(iterations_used));
          check_field("converged", 64'(want.conv), 64'(converged));
        end
      end
    end
  end

endmodule

// ----- tb/tb_cubic_fit_gradient_descent.sv -----
// top of the cubic fit testbench: clock, reset, stimulus and verdict
module tb_cubic_fit_gradient_descent;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [cfgd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int ITEM_GOAL = 1400;
  localparam int CALM_ITEMS = 200;
  localparam int HOLD_CYCLES = 2000;

  logic clk, rst;
  logic in_valid, in_ready, last_sample;
  logic signed [cfgd_pkg::X_W-1:0] sample_x;
  logic signed [cfgd_pkg::Y_W-1:0] sample_y;
  logic out_valid, out_ready, converged;
  logic signed [cfgd_pkg::COEF_W-1:0] coef_cubic, coef_square, coef_linear, coef_offset;
  logic [cfgd_pkg::ITER_W-1:0] iterations_used;
  logic cfg_valid, cfg_ready;
  logic [cfgd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cfgd_pkg::COEF_W-1:0] cfg_data;

  int fails, pending;
  int items_sent;
  int quiet_cycles;
  bit tx_idle, rx_idle, squeeze;

  cubic_fit_gradient_descent dut (.*);

  cubic_fit_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles with no transaction anywhere
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // result receiver with random stalls and one long hold-off
  initial begin
    bit held;
    held = 0;
    out_ready = 0;
    @(negedge rst);
    forever begin
      if (squeeze && !held) begin
        held = 1;
        out_ready <= 0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_idle && $urandom_range(0, 4) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ready <= 1;
        @(posedge clk);
      end
    end
  end

  // one sample transaction; valid stays up for a following sample
  task automatic send(logic signed [cfgd_pkg::X_W-1:0] x,
                      logic signed [cfgd_pkg::Y_W-1:0] y, logic l);
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1;
    sample_x <= x;
    sample_y <= y;
    last_sample <= l;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_batch(int n);
    logic [31:0] r;
    for (int i = 0; i < n; i++) begin
      r = $urandom;
      send(r[cfgd_pkg::X_W-1:0], r[cfgd_pkg::X_W+cfgd_pkg::Y_W-1:cfgd_pkg::X_W],
           i == n - 1);
    end
  endtask

  // register write, only once every fit has come out
  task automatic set_reg(logic [cfgd_pkg::CFG_IDX_W-1:0] idx,
                         logic [cfgd_pkg::COEF_W-1:0] val);
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  function automatic logic [cfgd_pkg::COEF_W-1:0] rand_coef();
    logic signed [cfgd_pkg::COEF_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return cfgd_pkg::S64_MAX;
      1: return cfgd_pkg::S64_MIN;
      2: return 64'd0;
      default: return v >>> $urandom_range(8, 40);
    endcase
  endfunction

  function automatic logic [cfgd_pkg::COEF_W-1:0] rand_rate();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return 64'hFFFF_FFFF;
      2: return 64'(cfgd_pkg::RST_LEARNING_RATE);
      default: return 64'($urandom >> $urandom_range(0, 31));
    endcase
  endfunction

  function automatic logic [cfgd_pkg::COEF_W-1:0] rand_thresh();
    case ($urandom_range(0, 4))
      0: return 64'd0;
      1: return 64'hFFFF_FFFF;
      default: return 64'($urandom >> $urandom_range(0, 31));
    endcase
  endfunction

  initial begin
    int n;
    rst = 1;
    in_valid = 0;
    sample_x = 0;
    sample_y = 0;
    last_sample = 0;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data = 0;
    tx_idle = 1;
    rx_idle = 1;
    squeeze = 0;
    items_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 0;

    // directed: field extremes with a short cap
    set_reg(cfgd_pkg::REG_MAX_ITER, 64'd3);
    send(8'sh80, 16'sh8000, 1'b0);
    send(8'sh7F, 16'sh7FFF, 1'b0);
    send(8'sh00, 16'sh0000, 1'b0);
    send(8'shFF, 16'shFFFF, 1'b0);
    send(8'sh01, 16'sh0001, 1'b1);
    send(8'sh55, 16'sh5555, 1'b0);
    send(8'shAA, 16'shAAAA, 1'b1);
    // zero iteration cap
    set_reg(cfgd_pkg::REG_MAX_ITER, 64'd0);
    send(8'sh03, 16'sh0007, 1'b1);
    // zero rate converges on the first iteration, even at the largest cap
    set_reg(cfgd_pkg::REG_LEARNING_RATE, 64'd0);
    set_reg(cfgd_pkg::REG_CONV_THRESH, 64'hFFFF_FFFF);
    set_reg(cfgd_pkg::REG_MAX_ITER, 64'hFF_FFFF);
    send(8'sh05, 16'shFFF7, 1'b0);
    send(8'shF9, 16'sh0064, 1'b1);
    // saturating coefficients, largest rate, threshold never met
    set_reg(cfgd_pkg::REG_LEARNING_RATE, 64'hFFFF_FFFF);
    set_reg(cfgd_pkg::REG_CONV_THRESH, 64'd0);
    set_reg(cfgd_pkg::REG_MAX_ITER, 64'd4);
    set_reg(cfgd_pkg::REG_INIT_CUBIC, cfgd_pkg::S64_MAX);
    set_reg(cfgd_pkg::REG_INIT_SQUARE, cfgd_pkg::S64_MIN);
    set_reg(cfgd_pkg::REG_INIT_LINEAR, cfgd_pkg::S64_MAX);
    set_reg(cfgd_pkg::REG_INIT_OFFSET, cfgd_pkg::S64_MIN);
    set_reg(REG_UNUSED, {$urandom, $urandom});
    send(8'sh7F, 16'sh8000, 1'b0);
    send(8'sh80, 16'sh7FFF, 1'b0);
    send(8'sh02, 16'sh0000, 1'b1);
    send(8'sh80, 16'sh7FFF, 1'b1);

    // random phases of configuration and batches
    for (int phase = 0; items_sent < ITEM_GOAL; phase++) begin
      if (items_sent > ITEM_GOAL - CALM_ITEMS) begin
        tx_idle = 0;
        rx_idle = 0;
      end
      if ($urandom_range(0, 2) == 0 || phase < 3) begin
        set_reg(cfgd_pkg::REG_LEARNING_RATE, rand_rate());
        set_reg(cfgd_pkg::REG_CONV_THRESH, rand_thresh());
        set_reg(cfgd_pkg::REG_MAX_ITER, 64'($urandom_range(1, 6)));
        set_reg(cfgd_pkg::REG_INIT_CUBIC, rand_coef());
        set_reg(cfgd_pkg::REG_INIT_SQUARE, rand_coef());
        set_reg(cfgd_pkg::REG_INIT_LINEAR, rand_coef());
        set_reg(cfgd_pkg::REG_INIT_OFFSET, rand_coef());
      end
      if (phase == 4) begin
        // overfilled store: extra samples dropped, last one still starts the fit
        set_reg(cfgd_pkg::REG_MAX_ITER, 64'd1);
        send_batch(1030);
      end else if (phase == 2) begin
        // long receiver hold-off while small batches keep coming
        set_reg(cfgd_pkg::REG_MAX_ITER, 64'd1);
        squeeze = 1;
        for (int b = 0; b < 6; b++) send_batch(2);
      end else begin
        for (int b = $urandom_range(1, 6); b > 0; b--) begin
          n = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
          send_batch(n);
        end
      end
    end

    // drain
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
